// ----- hdl/sopl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopl_pkg
// Shared constants and types for the saturated odd piecewise-linear curve:
// field widths, knee storage, controller states and the multiply/divide
// unit's request and status groups.
// ----------------------------------------------------------------------------
package sopl_pkg;

  localparam int DATA_W     = 32;               // signed in/out words
  localparam int FIELD_W    = 31;               // knee velocity / force fields
  localparam int ACC_W      = 2 * FIELD_W;      // product / remainder register
  localparam int CFG_W      = 63;               // widest register
  localparam int MAX_KNEES  = 8;                // curve points incl. origin
  localparam int KNEE_REGS  = MAX_KNEES - 1;    // programmable knees
  localparam int IDX_W      = $clog2(MAX_KNEES);
  localparam int NUM_W      = 4;                // knees_in_use width
  localparam int VEL_LSB    = 32;               // knee velocity position
  localparam int STEPS      = FIELD_W;          // bit steps for mul and div
  localparam int CNT_W      = $clog2(STEPS);

  // register indexes
  localparam logic [IDX_W-1:0] REG_KNEES_IN_USE = IDX_W'(KNEE_REGS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_SEARCH,
    S_ARITH,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic               start;
    logic [FIELD_W-1:0] dv;
    logic [FIELD_W-1:0] df_mag;
    logic [FIELD_W-1:0] span;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic [FIELD_W-1:0] quot;
  } md_stat_t;

endpackage

// ----- hdl/sopl_muldiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopl_muldiv
// Bit-serial unsigned multiply then restoring divide: (dv * df) / span,
// one bit per cycle for each phase, in a single shared 62-bit register.
// ----------------------------------------------------------------------------
module sopl_muldiv (
  input  logic               clk,
  input  logic               rst_n,
  input  sopl_pkg::md_req_t  req_i,
  output sopl_pkg::md_stat_t stat_o
);
  import sopl_pkg::*;

  md_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [FIELD_W-1:0] mcand_r, mcand_nxt;
  logic [FIELD_W-1:0] span_r, span_nxt;

  logic               cnt_last;
  logic [FIELD_W-1:0] addend;
  logic [FIELD_W:0]   sum;
  logic [FIELD_W:0]   trial;
  logic [FIELD_W+1:0] diff;
  logic               ge;
  logic [FIELD_W-1:0] rem_new;

  assign cnt_last = (cnt_r == CNT_W'(STEPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: if (req_i.start) state_nxt = MD_MUL;
      MD_MUL:  if (cnt_last) state_nxt = MD_DIV;
      MD_DIV:  if (cnt_last) state_nxt = MD_DONE;
      MD_DONE: state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    addend  = acc_r[0] ? mcand_r : '0;
    sum     = {1'b0, acc_r[ACC_W-1:FIELD_W]} + {1'b0, addend};
    trial   = {acc_r[ACC_W-1:FIELD_W], acc_r[FIELD_W-1]};
    diff    = {1'b0, trial} - {2'b00, span_r};
    ge      = ~diff[FIELD_W+1];
    // remainder stays below span, so it fits the field either way
    rem_new = ge ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];

    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    span_nxt  = span_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      MD_IDLE: begin
        if (req_i.start) begin
          acc_nxt   = {{FIELD_W{1'b0}}, req_i.dv};
          mcand_nxt = req_i.df_mag;
          span_nxt  = req_i.span;
          cnt_nxt   = '0;
        end
      end
      MD_MUL: begin
        // shift-add, multiplier bits leave from the bottom
        acc_nxt = {sum, acc_r[FIELD_W-1:1]};
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
      end
      MD_DIV: begin
        // restoring step, quotient bits enter from the bottom
        acc_nxt = {rem_new, acc_r[FIELD_W-2:0], ge};
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    span_r  <= span_nxt;
  end

  // outputs
  always_comb begin
    stat_o.done = (state_r == MD_DONE);
    stat_o.quot = acc_r[FIELD_W-1:0];
  end

endmodule

// ----- hdl/saturated_odd_piecewise_linear_curve.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturated_odd_piecewise_linear_curve
// Sequence: an accepted request first checks the last knee for saturation and
//   goes to the strobe on a hit; else the knees are walked one per cycle up to
//   the knee p reached (1..7), a flat or degenerate segment strobes from there,
//   and interpolation first runs the bit-serial multiply and then the divide.
// Throughput: one request at a time; the next is taken the cycle after the
//   strobe. Results cannot be stalled. Synchronous reset clears all knees
//   and sets knees_in_use to 2 (every input then gives force 0).
// ----------------------------------------------------------------------------
module saturated_odd_piecewise_linear_curve (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sopl_pkg::DATA_W-1:0]  in_rel_velocity,
  output logic                                out_valid,
  output logic signed [sopl_pkg::DATA_W-1:0]  out_damper_force,
  input  logic                                cfg_we,
  input  logic        [sopl_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [sopl_pkg::CFG_W-1:0]   cfg_data
);
  import sopl_pkg::*;

  ctl_state_t         state_r, state_nxt;
  logic [DATA_W-1:0]  mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [IDX_W-1:0]   p_r, p_nxt;
  logic [FIELD_W-1:0] lv_r, lv_nxt;
  logic [FIELD_W-1:0] lf_r, lf_nxt;
  logic               dfneg_r, dfneg_nxt;
  logic [DATA_W-1:0]  force_r, force_nxt;

  logic [FIELD_W-1:0] knee_vel_r [0:KNEE_REGS-1];
  logic [FIELD_W-1:0] knee_frc_r [0:KNEE_REGS-1];
  logic [NUM_W-1:0]   count_r;

  logic               accept;
  logic [DATA_W-1:0]  raw;
  logic [NUM_W-1:0]   count_m1;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   rd_slot;
  logic [FIELD_W-1:0] uv, uf;
  logic               sat_hit, found, flat, below;
  logic [DATA_W-1:0]  dv_full;
  logic [DATA_W-1:0]  q_ext;
  md_req_t            md_req;
  md_stat_t           md_stat;

  assign accept   = start && !busy;
  assign raw      = in_rel_velocity;
  assign count_m1 = count_r - 1'b1;

  // single read port onto the knee registers; origin knee lives in lv_r/lf_r
  assign rd_idx  = (state_r == S_LAST) ? last_r : p_r;
  assign rd_slot = rd_idx - 1'b1;
  assign uv      = knee_vel_r[rd_slot];
  assign uf      = knee_frc_r[rd_slot];

  assign sat_hit = (mag_r >= {1'b0, uv});
  assign found   = (mag_r <= {1'b0, uv});
  assign flat    = (uv <= lv_r);
  assign below   = (mag_r < {1'b0, lv_r});
  assign dv_full = mag_r - {1'b0, lv_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_LAST;
      S_LAST:   state_nxt = sat_hit ? S_DONE : S_SEARCH;
      S_SEARCH: begin
        if (found) begin
          state_nxt = (flat || below) ? S_DONE : S_ARITH;
        end
      end
      S_ARITH:  if (md_stat.done) state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    last_nxt  = last_r;
    p_nxt     = p_r;
    lv_nxt    = lv_r;
    lf_nxt    = lf_r;
    dfneg_nxt = dfneg_r;
    force_nxt = force_r;
    q_ext     = {1'b0, md_stat.quot};

    md_req.start  = 1'b0;
    md_req.dv     = dv_full[FIELD_W-1:0];
    md_req.df_mag = (uf >= lf_r) ? (uf - lf_r) : (lf_r - uf);
    md_req.span   = uv - lv_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt = raw[DATA_W-1];
          mag_nxt = raw[DATA_W-1] ? (~raw + 1'b1) : raw;
          // knee count saturates into 2..MAX_KNEES
          if (count_r < NUM_W'(2)) begin
            last_nxt = IDX_W'(1);
          end else if (count_r > NUM_W'(MAX_KNEES)) begin
            last_nxt = IDX_W'(MAX_KNEES - 1);
          end else begin
            last_nxt = count_m1[IDX_W-1:0];
          end
          p_nxt  = IDX_W'(1);
          lv_nxt = '0;
          lf_nxt = '0;
        end
      end
      S_LAST: begin
        if (sat_hit) force_nxt = {1'b0, uf};
      end
      S_SEARCH: begin
        if (found) begin
          if (flat || below) begin
            force_nxt = {1'b0, lf_r};
          end else begin
            md_req.start = 1'b1;
            dfneg_nxt    = (uf < lf_r);
          end
        end else begin
          lv_nxt = uv;
          lf_nxt = uf;
          p_nxt  = p_r + 1'b1;
        end
      end
      S_ARITH: begin
        if (md_stat.done) begin
          force_nxt = dfneg_r ? ({1'b0, lf_r} - q_ext) : ({1'b0, lf_r} + q_ext);
        end
      end
      default: ;
    endcase

    busy             = (state_r != S_IDLE);
    out_valid        = (state_r == S_DONE);
    out_damper_force = neg_r ? (~force_r + 1'b1) : force_r;
  end

  sopl_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (md_req),
    .stat_o (md_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    last_r  <= last_nxt;
    p_r     <= p_nxt;
    lv_r    <= lv_nxt;
    lf_r    <= lf_nxt;
    dfneg_r <= dfneg_nxt;
    force_r <= force_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KNEE_REGS; i++) begin
        knee_vel_r[i] <= '0;
        knee_frc_r[i] <= '0;
      end
      count_r <= NUM_W'(2);
    end else if (cfg_we) begin
      if (cfg_index == REG_KNEES_IN_USE) begin
        count_r <= cfg_data[NUM_W-1:0];
      end else begin
        knee_vel_r[cfg_index] <= cfg_data[VEL_LSB +: FIELD_W];
        knee_frc_r[cfg_index] <= cfg_data[FIELD_W-1:0];
      end
    end
  end

  // the walk never runs past the last knee in use
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (p_r <= last_r && p_r != '0))
    else $error("knee walk beyond last knee");

  // divider result only arrives while the controller waits for it
  a_md_done: assert property (@(posedge clk) disable iff (!rst_n)
    md_stat.done |-> (state_r == S_ARITH))
    else $error("multiply/divide done outside arithmetic phase");

  // an accepted request goes straight to the saturation check
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LAST))
    else $error("accepted request not started");

  // one strobe per request, block free right after it
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("strobe not followed by idle");

  // force magnitude at the strobe is never negative (interpolation stays within the segment's forces)
  a_force_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !force_r[DATA_W-1])
    else $error("force magnitude out of range");

endmodule
